### rtl/min_cost_assignment_solver_macros.svh
// assertion macros shared by the assignment solver rtl
// expects clk and arst_n in the scope of each use
`ifndef MIN_COST_ASSIGNMENT_SOLVER_MACROS_SVH
`define MIN_COST_ASSIGNMENT_SOLVER_MACROS_SVH
`ifndef SYNTHESIS
`define MCAS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mcas check failed");
`define MCAS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mcas check failed");
`else
`define MCAS_ASSERT_IMP(lbl, ante, cons)
`define MCAS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### rtl/mcas_pkg.sv
// shared constants and column cell command codes for the assignment solver
// no dependencies
package mcas_pkg;
	localparam int MAX_NODES_DEF   = 32;
	localparam int COST_WIDTH_DEF  = 16;
	localparam int LABEL_WIDTH_DEF = 32;
	localparam int TOTAL_W         = 21;
	localparam int FIELD_W         = 5;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_INIT,
		OP_CLEAR,
		OP_SEED,
		OP_RELAX,
		OP_MARK,
		OP_SHIFT,
		OP_MATE
	} mcas_op_e;
endpackage

### rtl/mcas_cell.sv
// one column cell: label, slack, parent row, mate and tree mark of one column
// depends on mcas_pkg; passes a running least slack on to its neighbour
module mcas_cell #(
	parameter int MAX_NODES   = 32,
	parameter int LABEL_WIDTH = 32,
	parameter int INDEX       = 0
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  mcas_pkg::mcas_op_e                     op,
	input  logic [$clog2(MAX_NODES)-1:0]           sel,
	input  logic signed [LABEL_WIDTH-1:0]          value,
	input  logic [$clog2(MAX_NODES)-1:0]           row,
	input  logic [$clog2(MAX_NODES+1)-1:0]         node_n,
	input  logic signed [LABEL_WIDTH-1:0]          min_in,
	output logic signed [LABEL_WIDTH-1:0]          min_out,
	output logic signed [LABEL_WIDTH-1:0]          label,
	output logic signed [LABEL_WIDTH-1:0]          slack,
	output logic [$clog2(MAX_NODES)-1:0]           parent,
	output logic [$clog2(MAX_NODES+1)-1:0]         mate,
	output logic                                   in_tree
);
	import mcas_pkg::*;

	localparam int IW = $clog2(MAX_NODES);
	localparam int NW = $clog2(MAX_NODES + 1);

	logic signed [LABEL_WIDTH-1:0] label_q, slack_q, min_q;
	logic [IW-1:0]                 parent_q;
	logic [NW-1:0]                 mate_q;
	logic                          in_tree_q;
	logic                          hit, active;

	assign hit    = (sel == IW'(INDEX));
	assign active = (NW'(INDEX) < node_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_tree_q <= 1'b0;
			mate_q    <= NW'(MAX_NODES);
			min_q     <= '0;
		end else begin
			min_q <= (active && !in_tree_q && slack_q < min_in) ? slack_q : min_in;
			unique case (op)
				OP_INIT: begin
					in_tree_q <= 1'b0;
					mate_q    <= NW'(MAX_NODES);
				end
				OP_CLEAR: in_tree_q <= 1'b0;
				OP_MARK: if (hit) in_tree_q <= 1'b1;
				OP_MATE: if (hit) mate_q <= NW'(row);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_INIT: label_q <= '0;
			OP_SEED: if (hit) begin
				slack_q  <= value;
				parent_q <= row;
			end
			OP_RELAX: if (hit && value < slack_q) begin
				slack_q  <= value;
				parent_q <= row;
			end
			OP_SHIFT: if (in_tree_q) begin
				label_q <= label_q - value;
			end else begin
				slack_q <= slack_q - value;
			end
			default: ;
		endcase
	end

	assign min_out = min_q;
	assign label   = label_q;
	assign slack   = slack_q;
	assign parent  = parent_q;
	assign mate    = mate_q;
	assign in_tree = in_tree_q;
endmodule

### rtl/min_cost_assignment_solver.sv
// Minimum-cost assignment solver (Hungarian method) built around a row of column cells.
// Load beats (tuser 0) write one cost entry each and are taken one per cycle while idle.
// A solve beat (tuser 1) runs the whole solve before the next beat is taken: one cost
// memory read per cycle drives the row minima, tree seeding and growth, and the total cost.
// Each label adjustment waits for the least slack to ripple down the cell chain and is
// followed by a column scan. Results then leave one per cycle while tready is high, n beats,
// the last with tlast and the total cost.
// depends on mcas_pkg, mcas_cell and min_cost_assignment_solver_macros.svh
`include "min_cost_assignment_solver_macros.svh"
module min_cost_assignment_solver #(
	parameter int MAX_NODES   = mcas_pkg::MAX_NODES_DEF,
	parameter int COST_WIDTH  = mcas_pkg::COST_WIDTH_DEF,
	parameter int LABEL_WIDTH = mcas_pkg::LABEL_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // row[4:0], column[9:5], cost_value[25:10], zero
	input  logic        s_tuser,  // kind[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // row_index[4:0], matched_column[9:5], total_cost[30:10], zero
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mcas_pkg::*;

	localparam int IW    = $clog2(MAX_NODES);
	localparam int NW    = $clog2(MAX_NODES + 1);
	localparam int AW    = $clog2(MAX_NODES * MAX_NODES);
	localparam int LCW   = $clog2(MAX_NODES + 1) + 1;
	localparam int TW    = COST_WIDTH + IW + 1;
	localparam int SUM_W = (TW > TOTAL_W) ? TW : TOTAL_W;
	localparam logic signed [LABEL_WIDTH-1:0] BIG =
		LABEL_WIDTH'(((64'd1 << (LABEL_WIDTH - 1)) - 64'd1) / 64'd4);

	typedef enum logic [3:0] {
		S_IDLE, S_ROW, S_TOT, S_DRAIN, S_AUG, S_ROOT, S_SCAN, S_LEAST, S_FLIP, S_EMIT
	} state_t;
	typedef enum logic [1:0] {P_MIN, P_ROOT, P_GROW, P_TOT} pass_t;

	state_t state_q;
	pass_t  pass_q;
	logic [5:0]    nc_q;
	logic [NW-1:0] n_eff;
	logic [NW-1:0] rx_q, c_q, k_q, y_q, steps_q, fy_q;
	logic [LCW-1:0] lcnt_q;

	logic signed [LABEL_WIDTH-1:0] row_label_q [MAX_NODES];
	logic [NW-1:0]                 row_mate_q  [MAX_NODES];
	logic [MAX_NODES-1:0]          row_in_tree_q;

	mcas_op_e                      cmd_op_q;
	logic [IW-1:0]                 cmd_sel_q, cmd_row_q;
	logic signed [LABEL_WIDTH-1:0] cmd_val_q;

	logic                          vld_s1;
	logic [IW-1:0]                 col_s1;
	logic signed [COST_WIDTH-1:0]  rdata_s1;
	logic signed [COST_WIDTH-1:0]  rowmin_q;
	logic signed [SUM_W-1:0]       sum_q;

	logic                m_tvalid_q, out_last_q;
	logic [FIELD_W-1:0]  out_row_q, out_col_q;
	logic [TOTAL_W-1:0]  out_tot_q;

	logic signed [COST_WIDTH-1:0] cost_mem [MAX_NODES * MAX_NODES];
	logic signed [COST_WIDTH-1:0] wdata;
	logic signed [15:0]           in_cost;
	logic [AW-1:0]                wr_addr, rd_addr;
	logic                         accept, mem_we;

	logic signed [LABEL_WIDTH-1:0] lab [MAX_NODES];
	logic signed [LABEL_WIDTH-1:0] slk [MAX_NODES];
	logic [IW-1:0]                 par [MAX_NODES];
	logic [NW-1:0]                 mat [MAX_NODES];
	logic [MAX_NODES-1:0]          itr;
	logic signed [LABEL_WIDTH-1:0] mc  [MAX_NODES+1];

	logic [IW-1:0]                 yi, par_y, rm_idx, tot_col;
	logic [NW-1:0]                 rm_rd;
	logic signed [LABEL_WIDTH-1:0] reduced;

	// column cell chain
	assign mc[0] = BIG;
	for (genvar g = 0; g < MAX_NODES; g++) begin : g_cell
		mcas_cell #(
			.MAX_NODES(MAX_NODES), .LABEL_WIDTH(LABEL_WIDTH), .INDEX(g)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .op(cmd_op_q), .sel(cmd_sel_q), .value(cmd_val_q),
			.row(cmd_row_q), .node_n(n_eff), .min_in(mc[g]), .min_out(mc[g+1]),
			.label(lab[g]), .slack(slk[g]), .parent(par[g]), .mate(mat[g]),
			.in_tree(itr[g])
		);
	end

	always_comb begin
		if (nc_q == 6'd0) n_eff = NW'(1);
		else if (nc_q > MAX_NODES) n_eff = NW'(MAX_NODES);
		else n_eff = NW'(nc_q);
	end

	assign in_cost = s_tdata[25:10];
	if (COST_WIDTH <= 16) begin : g_narrow
		assign wdata = in_cost[COST_WIDTH-1:0];
	end else begin : g_wide
		assign wdata = COST_WIDTH'(in_cost);
	end

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign mem_we   = accept && !s_tuser && (s_tdata[4:0] < MAX_NODES)
		&& (s_tdata[9:5] < MAX_NODES);
	assign wr_addr  = AW'(s_tdata[4:0] * MAX_NODES + s_tdata[9:5]);

	assign yi      = y_q[IW-1:0];
	assign par_y   = par[fy_q[IW-1:0]];
	assign rm_idx  = (state_q == S_FLIP) ? par_y : rx_q[IW-1:0];
	assign rm_rd   = row_mate_q[rm_idx];
	assign tot_col = (rm_rd == NW'(MAX_NODES)) ? '0 : rm_rd[IW-1:0];
	assign rd_addr = (state_q == S_TOT) ? AW'(rx_q * MAX_NODES + tot_col)
		: AW'(rx_q * MAX_NODES + c_q);
	assign reduced = LABEL_WIDTH'(rdata_s1) - row_label_q[rx_q[IW-1:0]] - lab[col_s1];

	always_ff @(posedge clk) begin
		if (mem_we) cost_mem[wr_addr] <= wdata;
		rdata_s1 <= cost_mem[rd_addr];
	end

	// configuration
	assign pready = 1'b1;
	assign prdata = (paddr == 3'd0) ? 32'(nc_q) : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_q <= 6'd32;
		end else if (psel && penable && pwrite && paddr == 3'd0) begin
			nc_q <= pwdata[5:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			pass_q        <= P_MIN;
			rx_q          <= '0;
			c_q           <= '0;
			k_q           <= '0;
			y_q           <= '0;
			steps_q       <= '0;
			fy_q          <= '0;
			lcnt_q        <= '0;
			row_in_tree_q <= '0;
			cmd_op_q      <= OP_NOP;
			cmd_sel_q     <= '0;
			cmd_row_q     <= '0;
			cmd_val_q     <= '0;
			vld_s1        <= 1'b0;
			col_s1        <= '0;
			rowmin_q      <= '0;
			sum_q         <= '0;
			m_tvalid_q    <= 1'b0;
			out_last_q    <= 1'b0;
			out_row_q     <= '0;
			out_col_q     <= '0;
			out_tot_q     <= '0;
			for (int i = 0; i < MAX_NODES; i++) begin
				row_label_q[i] <= '0;
				row_mate_q[i]  <= NW'(MAX_NODES);
			end
		end else begin
			cmd_op_q <= OP_NOP;
			vld_s1   <= 1'b0;
			if (vld_s1) begin
				case (pass_q)
					P_MIN: if (col_s1 == '0 || rdata_s1 < rowmin_q) rowmin_q <= rdata_s1;
					P_ROOT, P_GROW: begin
						cmd_op_q  <= (pass_q == P_ROOT) ? OP_SEED : OP_RELAX;
						cmd_sel_q <= col_s1;
						cmd_val_q <= reduced;
						cmd_row_q <= rx_q[IW-1:0];
					end
					default: sum_q <= sum_q + SUM_W'(rdata_s1);
				endcase
			end
			unique case (state_q)
				S_IDLE: if (accept && s_tuser) begin
					cmd_op_q <= OP_INIT;
					for (int i = 0; i < MAX_NODES; i++) row_mate_q[i] <= NW'(MAX_NODES);
					rx_q    <= '0;
					c_q     <= '0;
					pass_q  <= P_MIN;
					state_q <= S_ROW;
				end
				S_ROW: begin
					vld_s1 <= 1'b1;
					col_s1 <= c_q[IW-1:0];
					if (c_q == n_eff - NW'(1)) state_q <= S_DRAIN;
					else c_q <= c_q + NW'(1);
				end
				S_TOT: begin
					vld_s1 <= 1'b1;
					if (rx_q == n_eff - NW'(1)) state_q <= S_DRAIN;
					else rx_q <= rx_q + NW'(1);
				end
				S_DRAIN: if (!vld_s1 && cmd_op_q == OP_NOP) begin
					case (pass_q)
						P_MIN: begin
							row_label_q[rx_q[IW-1:0]] <= LABEL_WIDTH'(rowmin_q);
							if (rx_q == n_eff - NW'(1)) begin
								k_q     <= '0;
								state_q <= S_AUG;
							end else begin
								rx_q    <= rx_q + NW'(1);
								c_q     <= '0;
								state_q <= S_ROW;
							end
						end
						P_ROOT: begin
							y_q     <= '0;
							state_q <= S_SCAN;
						end
						P_GROW: begin
							y_q     <= y_q + NW'(1);
							state_q <= S_SCAN;
						end
						default: begin
							rx_q    <= '0;
							state_q <= S_EMIT;
						end
					endcase
				end
				S_AUG: if (k_q == n_eff) begin
					rx_q    <= '0;
					sum_q   <= '0;
					pass_q  <= P_TOT;
					state_q <= S_TOT;
				end else begin
					cmd_op_q      <= OP_CLEAR;
					row_in_tree_q <= '0;
					rx_q          <= '0;
					state_q       <= S_ROOT;
				end
				S_ROOT: if (rx_q >= n_eff) begin
					k_q     <= k_q + NW'(1);
					state_q <= S_AUG;
				end else if (rm_rd == NW'(MAX_NODES)) begin
					row_in_tree_q[rx_q[IW-1:0]] <= 1'b1;
					c_q     <= '0;
					pass_q  <= P_ROOT;
					state_q <= S_ROW;
				end else begin
					rx_q <= rx_q + NW'(1);
				end
				S_SCAN: if (cmd_op_q == OP_NOP) begin
					if (y_q == n_eff) begin
						lcnt_q  <= '0;
						state_q <= S_LEAST;
					end else if (!itr[yi] && slk[yi] == '0) begin
						if (mat[yi] >= n_eff) begin
							fy_q    <= y_q;
							steps_q <= '0;
							state_q <= S_FLIP;
						end else begin
							cmd_op_q  <= OP_MARK;
							cmd_sel_q <= yi;
							row_in_tree_q[mat[yi][IW-1:0]] <= 1'b1;
							rx_q    <= mat[yi];
							c_q     <= '0;
							pass_q  <= P_GROW;
							state_q <= S_ROW;
						end
					end else begin
						y_q <= y_q + NW'(1);
					end
				end
				S_LEAST: if (lcnt_q == LCW'(MAX_NODES)) begin
					cmd_op_q  <= OP_SHIFT;
					cmd_val_q <= mc[MAX_NODES];
					for (int i = 0; i < MAX_NODES; i++) begin
						if (row_in_tree_q[i]) row_label_q[i] <= row_label_q[i] + mc[MAX_NODES];
					end
					y_q     <= '0;
					state_q <= S_SCAN;
				end else begin
					lcnt_q <= lcnt_q + LCW'(1);
				end
				S_FLIP: if (steps_q < n_eff && fy_q < n_eff) begin
					row_mate_q[par_y] <= fy_q;
					cmd_op_q  <= OP_MATE;
					cmd_sel_q <= fy_q[IW-1:0];
					cmd_row_q <= par_y;
					fy_q      <= rm_rd;
					steps_q   <= steps_q + NW'(1);
				end else begin
					k_q     <= k_q + NW'(1);
					state_q <= S_AUG;
				end
				S_EMIT: if (!m_tvalid_q || m_tready) begin
					if (rx_q < n_eff) begin
						m_tvalid_q <= 1'b1;
						out_row_q  <= FIELD_W'(rx_q);
						out_col_q  <= FIELD_W'(rm_rd);
						out_last_q <= (rx_q == n_eff - NW'(1));
						out_tot_q  <= (rx_q == n_eff - NW'(1)) ? sum_q[TOTAL_W-1:0] : '0;
						rx_q       <= rx_q + NW'(1);
					end else begin
						m_tvalid_q <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {1'b0, out_tot_q, out_col_q, out_row_q};

	`MCAS_ASSERT_NXT(a_shift_after_wait, state_q == S_LEAST && lcnt_q == LCW'(MAX_NODES), cmd_op_q == OP_SHIFT)
	`MCAS_ASSERT_IMP(a_last_is_final_row, m_tvalid_q && out_last_q, out_row_q == FIELD_W'(n_eff - NW'(1)))
	`MCAS_ASSERT_IMP(a_read_only_in_pass, vld_s1, state_q == S_ROW || state_q == S_TOT || state_q == S_DRAIN)
endmodule

### verif/mcas_checker.sv
// result checker for the assignment solver: tracks the node count register and the
// cost matrix from the beats it sees, predicts each solve and compares the output beats
// depends on the solver port widths only
module mcas_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending,
	output int          solve_count,
	output int          result_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES = 32;
	localparam int NO_MATE = NODES;
	localparam longint BIG = 64'd536870911;

	typedef struct {
		logic [4:0]         row;
		logic [4:0]         col;
		logic signed [20:0] total;
		logic               last;
	} row_result_t;

	row_result_t assign_q[$];

	int     cost_m[NODES][NODES];
	longint row_lbl[NODES];
	longint col_lbl[NODES];
	longint slack[NODES];
	int     row_mate[NODES];
	int     col_mate[NODES];
	int     parent[NODES];
	bit     row_tree[NODES];
	bit     col_tree[NODES];
	int     match_cnt;
	logic [5:0] node_reg;

	initial begin
		foreach (cost_m[r, c]) cost_m[r][c] = 0;
	end

	function automatic longint reduced_cost(int x, int y);
		return longint'(cost_m[x][y]) - row_lbl[x] - col_lbl[y];
	endfunction

	function automatic void grow_tree(int x, int n);
		longint r;
		for (int y = 0; y < n; y++) begin
			r = reduced_cost(x, y);
			if (r < slack[y]) begin
				slack[y] = r;
				parent[y] = x;
			end
		end
	endfunction

	function automatic void augment_path(int n);
		int root;
		int y;
		int x;
		int nxt;
		int steps;
		bit found;
		longint least;
		found = 0;
		for (int i = 0; i < NODES; i++) begin
			row_tree[i] = 0;
			col_tree[i] = 0;
		end
		for (root = 0; root < n; root++)
			if (row_mate[root] == NO_MATE) break;
		if (root >= n) return;
		row_tree[root] = 1;
		for (int c = 0; c < n; c++) begin
			slack[c] = reduced_cost(root, c);
			parent[c] = root;
		end
		forever begin
			least = BIG;
			for (y = 0; y < n; y++) begin
				if (!col_tree[y] && slack[y] == 0) begin
					x = col_mate[y];
					if (x >= n) begin
						found = 1;
						break;
					end
					col_tree[y] = 1;
					row_tree[x] = 1;
					grow_tree(x, n);
				end
			end
			if (found) break;
			for (int c = 0; c < n; c++)
				if (!col_tree[c] && slack[c] < least) least = slack[c];
			for (int i = 0; i < n; i++) begin
				if (row_tree[i]) row_lbl[i] += least;
				if (col_tree[i]) col_lbl[i] -= least;
				else slack[i] -= least;
			end
		end
		match_cnt++;
		for (steps = 0; steps < n && y < n; steps++) begin
			x = parent[y] % NODES;
			nxt = row_mate[x];
			row_mate[x] = y;
			col_mate[y] = x;
			y = nxt;
		end
	endfunction

	function automatic void predict_assignment();
		int n;
		int m;
		longint total;
		row_result_t res;
		n = node_reg;
		if (n == 0) n = 1;
		if (n > NODES) n = NODES;
		for (int i = 0; i < NODES; i++) begin
			row_mate[i] = NO_MATE;
			col_mate[i] = NO_MATE;
		end
		match_cnt = 0;
		for (int x = 0; x < n; x++) begin
			m = cost_m[x][0];
			for (int y = 1; y < n; y++)
				if (cost_m[x][y] < m) m = cost_m[x][y];
			row_lbl[x] = m;
			col_lbl[x] = 0;
		end
		for (int k = 0; k < n && match_cnt < n; k++) augment_path(n);
		total = 0;
		for (int x = 0; x < n; x++) total += cost_m[x][row_mate[x] % NODES];
		for (int k = 0; k < n; k++) begin
			res.row = k[4:0];
			res.col = row_mate[k][4:0];
			res.last = (k + 1 == n);
			res.total = res.last ? total[20:0] : '0;
			assign_q.push_back(res);
		end
	endfunction

	function automatic void report(string what, row_result_t e);
		fail_count++;
		if (fail_count <= 10)
			$display("%t mismatch %s: expected row %0d col %0d total %0d last %0b, got row %0d col %0d total %0d last %0b",
				$realtime, what, e.row, e.col, e.total, e.last, m_tdata[4:0], m_tdata[9:5],
				$signed(m_tdata[30:10]), m_tlast);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		row_result_t e;
		if (!arst_n) begin
			node_reg = 6'd32;
			fail_count = 0;
			pending = 0;
			solve_count = 0;
			result_count = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == 3'd0)
				node_reg = pwdata[5:0];
			if (s_tvalid && s_tready) begin
				if (!s_tuser) begin
					cost_m[s_tdata[4:0]][s_tdata[9:5]] = int'($signed(s_tdata[25:10]));
				end else begin
					predict_assignment();
					solve_count++;
				end
			end
			if (m_tvalid && m_tready) begin
				result_count++;
				if (assign_q.size() == 0) begin
					e = '{default: '0};
					report("unexpected beat", e);
				end else begin
					e = assign_q.pop_front();
					if (m_tdata[4:0] !== e.row || m_tdata[9:5] !== e.col ||
					    m_tdata[30:10] !== e.total || m_tlast !== e.last)
						report("result", e);
				end
			end
			pending = assign_q.size();
		end
	end
endmodule

### verif/tb_min_cost_assignment_solver.sv
// stimulus top for the assignment solver: loads cost matrices, sets node counts over apb
// and issues solves; checking is done by mcas_checker, depends on min_cost_assignment_solver
module tb_min_cost_assignment_solver;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tuser = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic        psel = 0;
	logic        penable = 0;
	logic        pwrite = 0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int fail_count, pending, solve_count, result_count;
	bit loaded[32][32];
	int n_eff = 32;
	int items = 0;
	bit steady = 0;
	bit hold_req = 0;

	always #10 clk = ~clk;

	min_cost_assignment_solver u_dut (.*);

	mcas_checker u_check (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .m_tlast,
		.psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.fail_count, .pending, .solve_count, .result_count
	);

	initial begin
		#200ms;
		$display("CHECK FAILED");
		$finish;
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (3000) @(posedge clk);
				hold_req = 0;
			end else begin
				m_tready <= steady || $urandom_range(0, 99) >= 8;
			end
		end
	end

	function automatic logic [15:0] pick_cost();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 6) - 3);
			2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
			default: return 16'($urandom_range(0, 200) - 100);
		endcase
	endfunction

	task automatic send_beat(input bit kind, input logic [4:0] r, input logic [4:0] c,
			input logic [15:0] v);
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {6'b0, v, c, r};
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		items++;
		if (!steady && $urandom_range(0, 99) < 8) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic load_entry(input logic [4:0] r, input logic [4:0] c, input logic [15:0] v);
		send_beat(1'b0, r, c, v);
		loaded[r][c] = 1;
	endtask

	task automatic solve_matrix();
		for (int r = 0; r < n_eff; r++)
			for (int c = 0; c < n_eff; c++)
				if (!loaded[r][c]) load_entry(5'(r), 5'(c), pick_cost());
		send_beat(1'b1, 5'($urandom), 5'($urandom), 16'($urandom));
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(negedge clk);
		wait (pending == 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_nodes(input int v);
		wait_idle();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 3'd0;
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		n_eff = v == 0 ? 1 : (v > 32 ? 32 : v);
	endtask

	initial begin
		int n, k, phase;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: node count zero, single node extremes, ties, repeated solve
		set_nodes(0);
		load_entry(5'd0, 5'd0, 16'h8000);
		solve_matrix();
		set_nodes(1);
		load_entry(5'd0, 5'd0, 16'h7fff);
		solve_matrix();
		set_nodes(2);
		load_entry(5'd0, 5'd0, 16'h8000);
		load_entry(5'd0, 5'd1, 16'h7fff);
		load_entry(5'd1, 5'd0, 16'h7fff);
		load_entry(5'd1, 5'd1, 16'h8000);
		load_entry(5'd31, 5'd31, 16'h5555);
		load_entry(5'd21, 5'd10, 16'haaaa);
		solve_matrix();
		set_nodes(3);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++) load_entry(5'(r), 5'(c), 16'h0000);
		solve_matrix();
		solve_matrix();

		phase = 0;
		while (items < 480) begin
			phase++;
			steady = phase >= 6 && phase < 10;
			n = $urandom_range(0, 7) == 0 ? $urandom_range(9, 16) : $urandom_range(1, 8);
			set_nodes(n);
			if (phase == 3) hold_req = 1;
			repeat (2) begin
				k = $urandom_range(0, n * n);
				repeat (k) begin
					if ($urandom_range(0, 9) == 0)
						load_entry(5'($urandom), 5'($urandom), pick_cost());
					else
						load_entry(5'($urandom_range(0, n - 1)),
							5'($urandom_range(0, n - 1)), pick_cost());
				end
				solve_matrix();
			end
		end
		steady = 0;

		wait_idle();
		repeat (100) @(posedge clk);
		$display("run covered %0d input beats, %0d solves and %0d result beats",
			items, solve_count, result_count);
		$display("node counts zero to 16, loads outside the matrix, long output stall");
		if (fail_count == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

### files.f
+incdir+rtl
rtl/mcas_pkg.sv
rtl/mcas_cell.sv
rtl/min_cost_assignment_solver.sv
verif/mcas_checker.sv
verif/tb_min_cost_assignment_solver.sv
